### hdl/sdtfm_pkg.sv
// Package for the signed divider: operation codes and the control word
// that travels with each item through the divider array. No dependencies.
`default_nettype none

package sdtfm_pkg;

  typedef enum logic [1:0] {
    OP_TRUNC = 2'd0,
    OP_FLOOR = 2'd1,
    OP_MOD   = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0] op;
    logic       neg_a;
    logic       neg_b;
    logic       zero_b;
  } ctrl_t;

endpackage

`default_nettype wire

### hdl/sdtfm_if.sv
// Valid/ready channel interfaces for the operand word and the result word.
// No dependencies.
`default_nettype none

interface sdtfm_in_if #(
  parameter int W = 32
) ();
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic signed [W-1:0] dividend;
  logic signed [W-1:0] divisor;

  modport source (output valid, op, dividend, divisor, input ready);
  modport sink   (input valid, op, dividend, divisor, output ready);
endinterface

interface sdtfm_out_if #(
  parameter int W = 32
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

`default_nettype wire

### hdl/signed_divider_trunc_floor_mod.sv
// Signed divider with truncating quotient, floor quotient and floor modulo.
// Depends on sdtfm_pkg, sdtfm_if, sdtfm_front, sdtfm_cell and sdtfm_back.
//
// The operand word on req_i carries op, dividend and divisor; the result
// word leaves on rsp_o. Both channels use valid/ready and a word moves when
// both are high at a rising clock edge.
// The datapath is an entry stage, a row of WORD_BITS restoring division
// cells, one quotient bit each, and an output register.
// A new word can be accepted in every cycle; each stage holds its word until
// the next stage has room, so bubbles close up when the receiver stalls and
// the block keeps accepting until every stage is full.
// Results leave in the order the words were accepted.
// A zero divisor gives zero in every mode, as does the unused op code.
// Reset clears all stage valid flags; no word is in flight after reset.
`default_nettype none

module signed_divider_trunc_floor_mod #(
  parameter int WORD_BITS = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sdtfm_in_if.sink   req_i,
  sdtfm_out_if.source rsp_o
);

  logic             valid_w [0:WORD_BITS];
  logic             ready_w [0:WORD_BITS];
  sdtfm_pkg::ctrl_t ctrl_w  [0:WORD_BITS];
  logic [WORD_BITS-1:0] div_w [0:WORD_BITS];
  logic [WORD_BITS-1:0] rem_w [0:WORD_BITS];
  logic [WORD_BITS-1:0] quo_w [0:WORD_BITS];

  sdtfm_front #(.W(WORD_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (req_i.valid),
    .ready_o    (req_i.ready),
    .op_i       (req_i.op),
    .dividend_i (req_i.dividend),
    .divisor_i  (req_i.divisor),
    .valid_o    (valid_w[0]),
    .ready_i    (ready_w[0]),
    .ctrl_o     (ctrl_w[0]),
    .mag_a_o    (quo_w[0]),
    .mag_b_o    (div_w[0])
  );

  assign rem_w[0] = '0;

  for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
    sdtfm_cell #(.W(WORD_BITS)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_w[i]),
      .ready_o (ready_w[i]),
      .ctrl_i  (ctrl_w[i]),
      .div_i   (div_w[i]),
      .rem_i   (rem_w[i]),
      .quo_i   (quo_w[i]),
      .valid_o (valid_w[i+1]),
      .ready_i (ready_w[i+1]),
      .ctrl_o  (ctrl_w[i+1]),
      .div_o   (div_w[i+1]),
      .rem_o   (rem_w[i+1]),
      .quo_o   (quo_w[i+1])
    );
  end

  sdtfm_back #(.W(WORD_BITS)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_w[WORD_BITS]),
    .ready_o  (ready_w[WORD_BITS]),
    .ctrl_i   (ctrl_w[WORD_BITS]),
    .div_i    (div_w[WORD_BITS]),
    .rem_i    (rem_w[WORD_BITS]),
    .quo_i    (quo_w[WORD_BITS]),
    .valid_o  (rsp_o.valid),
    .ready_i  (rsp_o.ready),
    .result_o (rsp_o.result)
  );

endmodule

`default_nettype wire

### hdl/sdtfm_front.sv
// Entry stage: takes the operand word, registers operand magnitudes and the
// control word for the divider cells. Depends on sdtfm_pkg.
`default_nettype none

module sdtfm_front #(
  parameter int W = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire logic [1:0]        op_i,
  input  wire logic [W-1:0]      dividend_i,
  input  wire logic [W-1:0]      divisor_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output sdtfm_pkg::ctrl_t       ctrl_o,
  output logic [W-1:0]           mag_a_o,
  output logic [W-1:0]           mag_b_o
);

  logic             valid_q;
  sdtfm_pkg::ctrl_t ctrl_d, ctrl_q;
  logic [W-1:0]     mag_a_d, mag_a_q;
  logic [W-1:0]     mag_b_d, mag_b_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    ctrl_d.op     = op_i;
    ctrl_d.neg_a  = dividend_i[W-1];
    ctrl_d.neg_b  = divisor_i[W-1];
    ctrl_d.zero_b = (divisor_i == '0);
    mag_a_d = dividend_i[W-1] ? (~dividend_i + 1'b1) : dividend_i;
    mag_b_d = divisor_i[W-1] ? (~divisor_i + 1'b1) : divisor_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ctrl_q  <= ctrl_d;
      mag_a_q <= mag_a_d;
      mag_b_q <= mag_b_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign mag_a_o = mag_a_q;
  assign mag_b_o = mag_b_q;

endmodule

`default_nettype wire

### hdl/sdtfm_cell.sv
// One restoring division cell: develops one quotient bit per item and hands
// the partial remainder and shifted quotient to the next cell. Depends on
// sdtfm_pkg.
`default_nettype none

module sdtfm_cell #(
  parameter int W = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire sdtfm_pkg::ctrl_t  ctrl_i,
  input  wire logic [W-1:0]      div_i,
  input  wire logic [W-1:0]      rem_i,
  input  wire logic [W-1:0]      quo_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output sdtfm_pkg::ctrl_t       ctrl_o,
  output logic [W-1:0]           div_o,
  output logic [W-1:0]           rem_o,
  output logic [W-1:0]           quo_o
);

  logic             valid_q;
  sdtfm_pkg::ctrl_t ctrl_q;
  logic [W-1:0]     div_q;
  logic [W-1:0]     rem_d, rem_q;
  logic [W-1:0]     quo_d, quo_q;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             fits;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    trial = {rem_i, quo_i[W-1]};
    diff  = trial - {1'b0, div_i};
    fits  = !diff[W];
    rem_d = fits ? diff[W-1:0] : trial[W-1:0];
    quo_d = {quo_i[W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ctrl_q <= ctrl_i;
      div_q  <= div_i;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign div_o   = div_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;

endmodule

`default_nettype wire

### hdl/sdtfm_back.sv
// Output stage: applies signs, floor correction and the modulo fix-up to the
// unsigned quotient and remainder, and holds the result word. Depends on
// sdtfm_pkg.
`default_nettype none

module sdtfm_back #(
  parameter int W = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire sdtfm_pkg::ctrl_t  ctrl_i,
  input  wire logic [W-1:0]      div_i,
  input  wire logic [W-1:0]      rem_i,
  input  wire logic [W-1:0]      quo_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [W-1:0]           result_o
);

  logic         valid_q;
  logic [W-1:0] result_d, result_q;
  logic         signs_differ;
  logic         rem_nz;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    signs_differ = ctrl_i.neg_a ^ ctrl_i.neg_b;
    rem_nz       = (rem_i != '0);
    case (ctrl_i.op)
      sdtfm_pkg::OP_TRUNC: begin
        result_d = signs_differ ? (~quo_i + 1'b1) : quo_i;
      end
      sdtfm_pkg::OP_FLOOR: begin
        if (!signs_differ) begin
          result_d = quo_i;
        end else if (rem_nz) begin
          result_d = ~quo_i;
        end else begin
          result_d = ~quo_i + 1'b1;
        end
      end
      sdtfm_pkg::OP_MOD: begin
        if (signs_differ && rem_nz) begin
          result_d = ctrl_i.neg_b ? (rem_i - div_i) : (div_i - rem_i);
        end else begin
          result_d = ctrl_i.neg_a ? (~rem_i + 1'b1) : rem_i;
        end
      end
      default: begin
        result_d = '0;
      end
    endcase
    if (ctrl_i.zero_b) begin
      result_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

### hdl/sdtfm_checker.sv
// Port-level checks for the signed divider, bound to the top level.
// Depends on signed_divider_trunc_floor_mod and its channel interfaces.
`default_nettype none

module sdtfm_checker #(
  parameter int W = 32
) (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         in_valid_i,
  input wire logic         in_ready_i,
  input wire logic         out_valid_i,
  input wire logic         out_ready_i,
  input wire logic [W-1:0] result_i
);

  localparam int Depth = W + 2;
  localparam int CntBits = $clog2(Depth + 2);

  logic               in_acc;
  logic               out_acc;
  logic [CntBits-1:0] count_d, count_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    count_d = count_q;
    if (in_acc && !out_acc) begin
      count_d = count_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Result word withdrawn while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(result_i))
    else $error("Result word changed while stalled.");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> count_q != '0)
    else $error("Result offered with no word in flight.");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(Depth))
    else $error("More words in flight than pipeline stages.");

endmodule

bind signed_divider_trunc_floor_mod sdtfm_checker #(.W(WORD_BITS)) u_sdtfm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .result_i    (rsp_o.result)
);

`default_nettype wire
